>>> design/assert_macros.svh
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/rld_pkg.sv
// types and constants of the literal/repeat run-length decoder
package rld_pkg;

    localparam int LENGTH_BITS = 32;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CTRL    = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;
    localparam logic [1:0] PH_REPEAT  = 2'd3;

    localparam logic [7:0] LITERAL_FLAG  = 8'h80;
    localparam logic [7:0] LOW7_MASK     = 8'h7F;
    localparam logic [7:0] REPEAT_OFFSET = 8'd3;

    typedef struct packed {
        logic [1:0]             phase;
        logic [1:0]             header_bytes_seen;
        logic [LENGTH_BITS-1:0] bytes_remaining;
        logic [7:0]             run_left;
    } state_t;

    typedef struct packed {
        logic [7:0] out_value;
        logic [7:0] run_count;
        logic       end_of_stream;
    } result_t;

endpackage

>>> design/rld_step.sv
// next-state and result logic for one compressed word
module rld_step
(
    input  rld_pkg::state_t  state,
    input  logic [7:0]       in_byte,
    output rld_pkg::state_t  state_next,
    output logic             result_valid,
    output rld_pkg::result_t result
);

    logic [31:0]                     header_acc;
    logic [rld_pkg::LENGTH_BITS-1:0] header_len;
    logic [rld_pkg::LENGTH_BITS-1:0] lit_remaining;
    logic [7:0]                      lit_left;
    logic [rld_pkg::LENGTH_BITS-1:0] rep_wide;
    logic [rld_pkg::LENGTH_BITS-1:0] rep_cnt;
    logic [rld_pkg::LENGTH_BITS-1:0] rep_remaining;

    always_comb
    begin
        header_acc = ((state.header_bytes_seen == 2'd0) ? 32'd0
                      : 32'(state.bytes_remaining))
                     | (32'(in_byte) << {state.header_bytes_seen, 3'b000});
        header_len = header_acc[rld_pkg::LENGTH_BITS-1:0];

        lit_remaining = state.bytes_remaining - rld_pkg::LENGTH_BITS'(1);
        lit_left      = state.run_left - 8'd1;

        // repeat run clamped to the bytes still owed
        rep_wide      = rld_pkg::LENGTH_BITS'(state.run_left);
        rep_cnt       = (rep_wide > state.bytes_remaining) ? state.bytes_remaining : rep_wide;
        rep_remaining = state.bytes_remaining - rep_cnt;
    end

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result       = '{out_value: in_byte, run_count: 8'd1, end_of_stream: 1'b0};
        unique case (state.phase)
            rld_pkg::PH_HEADER:
            begin
                state_next.bytes_remaining = header_len;
                if (state.header_bytes_seen != 2'd3)
                begin
                    state_next.header_bytes_seen = state.header_bytes_seen + 2'd1;
                end
                else
                begin
                    state_next.header_bytes_seen = 2'd0;
                    state_next.run_left          = 8'd0;
                    if (header_len == '0)
                    begin
                        result_valid = 1'b1;
                        result       = '{out_value: 8'd0, run_count: 8'd0,
                                         end_of_stream: 1'b1};
                    end
                    else
                    begin
                        state_next.phase = rld_pkg::PH_CTRL;
                    end
                end
            end
            rld_pkg::PH_CTRL:
            begin
                if ((in_byte & rld_pkg::LITERAL_FLAG) != 8'd0)
                begin
                    state_next.run_left = (in_byte & rld_pkg::LOW7_MASK) + 8'd1;
                    state_next.phase    = rld_pkg::PH_LITERAL;
                end
                else
                begin
                    state_next.run_left = in_byte + rld_pkg::REPEAT_OFFSET;
                    state_next.phase    = rld_pkg::PH_REPEAT;
                end
            end
            rld_pkg::PH_LITERAL:
            begin
                result_valid               = 1'b1;
                result.end_of_stream       = (lit_remaining == '0);
                state_next.bytes_remaining = lit_remaining;
                state_next.run_left        = lit_left;
                if (lit_remaining == '0)
                begin
                    state_next.phase             = rld_pkg::PH_HEADER;
                    state_next.header_bytes_seen = 2'd0;
                    state_next.run_left          = 8'd0;
                end
                else if (lit_left == 8'd0)
                begin
                    state_next.phase = rld_pkg::PH_CTRL;
                end
            end
            rld_pkg::PH_REPEAT:
            begin
                result_valid               = 1'b1;
                result.run_count           = rep_cnt[7:0];
                result.end_of_stream       = (rep_remaining == '0);
                state_next.bytes_remaining = rep_remaining;
                state_next.run_left        = 8'd0;
                if (rep_remaining == '0)
                begin
                    state_next.phase             = rld_pkg::PH_HEADER;
                    state_next.header_bytes_seen = 2'd0;
                end
                else
                begin
                    state_next.phase = rld_pkg::PH_CTRL;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

>>> design/rle_literal_repeat_decoder.sv
// top level of the literal/repeat run-length decoder
// a word taken into stage 1 is decoded and its run registered at the outputs
// throughput: one word per cycle unless stalled, set by the single-pass decoder
// header and ctrl words update state only; an empty header gives end_of_stream
// reset: asynchronous active low, clears decode state and both stage valids
`include "assert_macros.svh"

module rle_literal_repeat_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_value,
    output logic [7:0] run_count,
    output logic       end_of_stream
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [7:0]       s1_byte_reg;
    rld_pkg::state_t  state_reg;
    rld_pkg::state_t  state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rld_pkg::result_t result_reg;
    rld_pkg::result_t step_result;
    logic             step_valid;
    logic             advance;
    logic             in_take;

    // stage 1 moves on when the output register is free or being emptied
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    rld_step u_step
    (
        .state        (state_reg),
        .in_byte      (s1_byte_reg),
        .state_next   (state_next),
        .result_valid (step_valid),
        .result       (step_result)
    );

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !advance);
        out_valid_next = out_valid_reg && out_stall;
        if (s1_valid_reg && advance)
        begin
            out_valid_next = step_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: rld_pkg::PH_HEADER, header_bytes_seen: 2'd0,
                               bytes_remaining: '0, run_left: 8'd0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s1_valid_reg && advance && step_valid)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = result_reg.out_value;
    assign run_count     = result_reg.run_count;
    assign end_of_stream = result_reg.end_of_stream;

    `ASSERT_IMPLIES(a_empty_run_ends, out_valid_reg && (result_reg.run_count == 8'd0), result_reg.end_of_stream, "zero-length run without end of stream")
    `ASSERT_IMPLIES(a_owed_in_body, state_reg.phase != rld_pkg::PH_HEADER, state_reg.bytes_remaining != '0, "stream body with nothing owed")
    `ASSERT_IMPLIES(a_literal_left, state_reg.phase == rld_pkg::PH_LITERAL, state_reg.run_left != 8'd0, "literal phase with empty run")
    `ASSERT_IMPLIES(a_header_clean, state_reg.phase == rld_pkg::PH_HEADER, state_reg.run_left == 8'd0, "header phase with pending run")

endmodule
